@@ hdl/mcsg_pkg.sv @@
// Shared types and constants of the midpoint circle span generator.
`timescale 1ns / 1ps
package mcsg_pkg;

   localparam int IN_BITS   = 10;
   localparam int COLOR_BITS = 16;
   localparam int SPAN_BITS = 12;
   localparam int COORD_MAX = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   localparam logic MODE_OUTLINE = 1'b0;
   localparam logic MODE_FILLED  = 1'b1;

   localparam logic [2:0] LAST_IDX_EMPTY   = 3'd0;
   localparam logic [2:0] LAST_IDX_FILLED  = 3'd3;
   localparam logic [2:0] LAST_IDX_OUTLINE = 3'd7;

   typedef struct packed {
      logic                          empty;
      logic                          finished;
      logic                          fill;
      logic [COLOR_BITS-1:0]         color;
      logic [COORD_MAX-1:0]          cx;
      logic [COORD_MAX-1:0]          cy;
      logic signed [COORD_MAX:0]     x;
      logic signed [COORD_MAX:0]     y;
   } span_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/mcsg_front.sv @@
// Front end: accepts transactions, holds the circle walk and queues step work.
`timescale 1ns / 1ps
module mcsg_front #(
   parameter int COORD_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [mcsg_pkg::IN_BITS-1:0]        req_center_x,
   input  logic [mcsg_pkg::IN_BITS-1:0]        req_center_y,
   input  logic [mcsg_pkg::IN_BITS-1:0]        req_radius,
   input  logic                                req_fill_mode,
   input  logic [mcsg_pkg::COLOR_BITS-1:0]     req_color,
   input  mcsg_pkg::queue_status_type          q_status,
   output logic                                push,
   output mcsg_pkg::span_desc_type             push_desc
);

   localparam int CB = COORD_BITS;
   localparam int XW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 5;
   localparam logic signed [EW-1:0] E_ONE = EW'(1);
   localparam logic signed [EW-1:0] E_TWO = EW'(2);
   localparam logic signed [XW-1:0] X_ONE = XW'(1);

   logic                          busy_ff, busy_in;
   logic                          mode_ff, mode_in;
   logic [CB-1:0]                 cx_ff, cx_in;
   logic [CB-1:0]                 cy_ff, cy_in;
   logic [CB-1:0]                 rad_ff, rad_in;
   logic [mcsg_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic signed [XW-1:0]          wx_ff, wx_in;
   logic signed [XW-1:0]          wy_ff, wy_in;
   logic signed [EW-1:0]          err_ff, err_in;
   logic signed [EW-1:0]          xinc_ff, xinc_in;
   logic signed [EW-1:0]          yinc_ff, yinc_in;

   logic                          accept;
   logic                          active;
   logic [CB-1:0]                 new_rad;
   logic signed [XW-1:0]          new_rad_x;
   logic signed [EW-1:0]          new_two_r;
   logic signed [EW-1:0]          two_r;
   logic                          step_y, step_x;
   logic signed [EW-1:0]          e_a, yi_a, xi_b, e_b;
   logic signed [XW-1:0]          y_a, x_b;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign active    = busy_ff && !(wx_ff < wy_ff);

   assign new_rad   = CB'(req_radius);
   assign new_rad_x = XW'(signed'({1'b0, new_rad}));
   assign new_two_r = EW'(signed'({1'b0, new_rad})) <<< 1;
   assign two_r     = EW'(signed'({1'b0, rad_ff})) <<< 1;

   always_comb begin
      if (mode_ff == mcsg_pkg::MODE_OUTLINE) begin
         step_y = (err_ff <= 0);
         e_a    = step_y ? err_ff + yinc_ff : err_ff;
         yi_a   = step_y ? yinc_ff + E_TWO : yinc_ff;
         y_a    = step_y ? wy_ff + X_ONE : wy_ff;
         xi_b   = xinc_ff + E_TWO;
         step_x = (e_a > 0);
         e_b    = e_a + xi_b - two_r;
      end else begin
         step_y = 1'b1;
         e_a    = err_ff + yinc_ff;
         yi_a   = yinc_ff + E_TWO;
         y_a    = wy_ff + X_ONE;
         xi_b   = xinc_ff + E_TWO;
         step_x = ((e_a <<< 1) + xinc_ff > 0);
         e_b    = e_a + xinc_ff;
      end
      x_b = wx_ff - X_ONE;
   end

   always_comb begin
      busy_in  = busy_ff;
      mode_in  = mode_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rad_in   = rad_ff;
      color_in = color_ff;
      wx_in    = wx_ff;
      wy_in    = wy_ff;
      err_in   = err_ff;
      xinc_in  = xinc_ff;
      yinc_in  = yinc_ff;
      push     = 1'b0;

      push_desc.empty    = !active;
      push_desc.finished = 1'b1;
      push_desc.fill     = mode_ff;
      push_desc.color    = color_ff;
      push_desc.cx       = mcsg_pkg::COORD_MAX'(cx_ff);
      push_desc.cy       = mcsg_pkg::COORD_MAX'(cy_ff);
      push_desc.x        = (mcsg_pkg::COORD_MAX + 1)'(wx_ff);
      push_desc.y        = (mcsg_pkg::COORD_MAX + 1)'(wy_ff);

      if (accept) begin
         if (req_action == mcsg_pkg::ACTION_START) begin
            busy_in  = 1'b1;
            mode_in  = req_fill_mode;
            cx_in    = CB'(req_center_x);
            cy_in    = CB'(req_center_y);
            rad_in   = new_rad;
            color_in = req_color;
            wy_in    = '0;
            if (req_fill_mode == mcsg_pkg::MODE_OUTLINE) begin
               wx_in   = new_rad_x - X_ONE;
               xinc_in = E_ONE;
               yinc_in = E_ONE;
               err_in  = E_ONE - new_two_r;
            end else begin
               wx_in   = new_rad_x;
               xinc_in = E_ONE - new_two_r;
               yinc_in = '0;
               err_in  = '0;
            end
         end else begin
            push = 1'b1;
            if (active) begin
               wy_in   = y_a;
               yinc_in = yi_a;
               err_in  = step_x ? e_b : e_a;
               xinc_in = step_x ? xi_b : xinc_ff;
               wx_in   = step_x ? x_b : wx_ff;
               push_desc.finished = ((step_x ? x_b : wx_ff) < y_a);
               busy_in = !push_desc.finished;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         mode_ff  <= 1'b0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         rad_ff   <= '0;
         color_ff <= '0;
         wx_ff    <= '0;
         wy_ff    <= '0;
         err_ff   <= '0;
         xinc_ff  <= '0;
         yinc_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         mode_ff  <= mode_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         rad_ff   <= rad_in;
         color_ff <= color_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         err_ff   <= err_in;
         xinc_ff  <= xinc_in;
         yinc_ff  <= yinc_in;
      end
   end

endmodule

@@ hdl/mcsg_queue.sv @@
// Two-entry queue of step descriptors between front and back end.
`timescale 1ns / 1ps
module mcsg_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mcsg_pkg::span_desc_type     push_desc,
   input  logic                        pop,
   output mcsg_pkg::span_desc_type     head_desc,
   output mcsg_pkg::queue_status_type  status
);

   localparam int PW = $clog2(mcsg_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(mcsg_pkg::QUEUE_DEPTH + 1);

   mcsg_pkg::span_desc_type entry_ff [mcsg_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == CW'(mcsg_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(mcsg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(mcsg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/mcsg_back.sv @@
// Back end: expands a step descriptor into registered spans, one per cycle unless stalled.
`timescale 1ns / 1ps
module mcsg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mcsg_pkg::span_desc_type               head_desc,
   input  mcsg_pkg::queue_status_type            q_status,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_left,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_right,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_row,
   output logic [mcsg_pkg::COLOR_BITS-1:0]       rsp_span_color,
   output logic                                  rsp_span_valid,
   output logic                                  rsp_last_in_step,
   output logic                                  rsp_finished
);

   localparam int SW = mcsg_pkg::COORD_MAX + 3;
   localparam int OW = mcsg_pkg::SPAN_BITS;

   logic [2:0]           idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic signed [OW-1:0] left_ff, left_in;
   logic signed [OW-1:0] right_ff, right_in;
   logic signed [OW-1:0] row_ff, row_in;
   logic [mcsg_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic                 sv_ff, sv_in;
   logic                 last_ff, last_in;
   logic                 fin_ff, fin_in;

   logic                 load, is_last;
   logic [2:0]           last_idx;
   logic signed [SW-1:0] cx_s, cy_s, x_s, y_s;
   logic signed [OW-1:0] cx_px, cx_mx, cx_py, cx_my, cy_px, cy_mx, cy_py, cy_my;

   assign cx_s = SW'(signed'({1'b0, head_desc.cx}));
   assign cy_s = SW'(signed'({1'b0, head_desc.cy}));
   assign x_s  = SW'(head_desc.x);
   assign y_s  = SW'(head_desc.y);

   assign cx_px = OW'(cx_s + x_s);
   assign cx_mx = OW'(cx_s - x_s);
   assign cx_py = OW'(cx_s + y_s);
   assign cx_my = OW'(cx_s - y_s);
   assign cy_px = OW'(cy_s + x_s);
   assign cy_mx = OW'(cy_s - x_s);
   assign cy_py = OW'(cy_s + y_s);
   assign cy_my = OW'(cy_s - y_s);

   always_comb begin
      if (head_desc.empty) begin
         last_idx = mcsg_pkg::LAST_IDX_EMPTY;
      end else if (head_desc.fill == mcsg_pkg::MODE_FILLED) begin
         last_idx = mcsg_pkg::LAST_IDX_FILLED;
      end else begin
         last_idx = mcsg_pkg::LAST_IDX_OUTLINE;
      end
   end

   assign load    = !q_status.empty && (!valid_ff || rsp_ready);
   assign is_last = (idx_ff == last_idx);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      left_in  = left_ff;
      right_in = right_ff;
      row_in   = row_ff;
      color_in = color_ff;
      sv_in    = sv_ff;
      last_in  = last_ff;
      fin_in   = fin_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
         last_in  = is_last;
         fin_in   = is_last && head_desc.finished;
         sv_in    = !head_desc.empty;
         color_in = head_desc.empty ? '0 : head_desc.color;
         if (head_desc.empty) begin
            left_in  = '0;
            right_in = '0;
            row_in   = '0;
         end else if (head_desc.fill == mcsg_pkg::MODE_FILLED) begin
            case (idx_ff)
               3'd0: begin left_in = cx_mx; right_in = cx_px; row_in = cy_py; end
               3'd1: begin left_in = cx_mx; right_in = cx_px; row_in = cy_my; end
               3'd2: begin left_in = cx_my; right_in = cx_py; row_in = cy_px; end
               default: begin left_in = cx_my; right_in = cx_py; row_in = cy_mx; end
            endcase
         end else begin
            case (idx_ff)
               3'd0: begin left_in = cx_px; row_in = cy_py; end
               3'd1: begin left_in = cx_py; row_in = cy_px; end
               3'd2: begin left_in = cx_my; row_in = cy_px; end
               3'd3: begin left_in = cx_mx; row_in = cy_py; end
               3'd4: begin left_in = cx_mx; row_in = cy_my; end
               3'd5: begin left_in = cx_my; row_in = cy_mx; end
               3'd6: begin left_in = cx_py; row_in = cy_mx; end
               default: begin left_in = cx_px; row_in = cy_my; end
            endcase
            right_in = left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      row_ff   <= row_in;
      color_ff <= color_in;
      sv_ff    <= sv_in;
      last_ff  <= last_in;
      fin_ff   <= fin_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_span_left    = left_ff;
   assign rsp_span_right   = right_ff;
   assign rsp_span_row     = row_ff;
   assign rsp_span_color   = color_ff;
   assign rsp_span_valid   = sv_ff;
   assign rsp_last_in_step = last_ff;
   assign rsp_finished     = fin_ff;

endmodule

@@ hdl/midpoint_circle_span_generator.sv @@
// Top level of the midpoint circle span generator.
//
//   channel | direction | handshake             | carries
//   req_    | in        | req_valid/req_ready   | start or step transaction
//   rsp_    | out       | rsp_valid/rsp_ready   | spans of step transactions
//
// A start transaction gives no span. A step gives eight spans (outline), four
// (filled) or one empty result, one per cycle from the back end's output register
// while rsp_ready stays high.
// The front end takes the next transaction while the back end drains, through a
// two-entry descriptor queue; req_ready drops only when that queue is full.
// Synchronous reset clears the walk state, the queue and the output valid.
`timescale 1ns / 1ps
module midpoint_circle_span_generator #(
   parameter int COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [mcsg_pkg::IN_BITS-1:0]          req_center_x,
   input  logic [mcsg_pkg::IN_BITS-1:0]          req_center_y,
   input  logic [mcsg_pkg::IN_BITS-1:0]          req_radius,
   input  logic                                  req_fill_mode,
   input  logic [mcsg_pkg::COLOR_BITS-1:0]       req_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_left,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_right,
   output logic signed [mcsg_pkg::SPAN_BITS-1:0] rsp_span_row,
   output logic [mcsg_pkg::COLOR_BITS-1:0]       rsp_span_color,
   output logic                                  rsp_span_valid,
   output logic                                  rsp_last_in_step,
   output logic                                  rsp_finished
);

   logic                        push, pop;
   mcsg_pkg::span_desc_type     push_desc, head_desc;
   mcsg_pkg::queue_status_type  q_status;

   mcsg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_fill_mode(req_fill_mode),
      .req_color    (req_color),
      .q_status     (q_status),
      .push         (push),
      .push_desc    (push_desc)
   );

   mcsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   mcsg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_desc        (head_desc),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_span_left    (rsp_span_left),
      .rsp_span_right   (rsp_span_right),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_color   (rsp_span_color),
      .rsp_span_valid   (rsp_span_valid),
      .rsp_last_in_step (rsp_last_in_step),
      .rsp_finished     (rsp_finished)
   );

   a_finished_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_last_in_step)
      else $error("finished mark without last-in-step mark");

   a_empty_result_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_last_in_step && rsp_finished)
      else $error("empty result not marked last and finished");

   a_step_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == mcsg_pkg::ACTION_STEP
      |=> !q_status.empty)
      else $error("step transaction lost before the queue");

endmodule

@@ dv/circle_span_monitor.sv @@
// Channel monitor that predicts and checks the spans of the circle span generator.
`timescale 1ns / 1ps
module circle_span_monitor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_action,
   input  logic [mcsg_pkg::IN_BITS-1:0]           req_center_x,
   input  logic [mcsg_pkg::IN_BITS-1:0]           req_center_y,
   input  logic [mcsg_pkg::IN_BITS-1:0]           req_radius,
   input  logic                                   req_fill_mode,
   input  logic [mcsg_pkg::COLOR_BITS-1:0]        req_color,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [mcsg_pkg::SPAN_BITS-1:0]  rsp_span_left,
   input  logic signed [mcsg_pkg::SPAN_BITS-1:0]  rsp_span_right,
   input  logic signed [mcsg_pkg::SPAN_BITS-1:0]  rsp_span_row,
   input  logic [mcsg_pkg::COLOR_BITS-1:0]        rsp_span_color,
   input  logic                                   rsp_span_valid,
   input  logic                                   rsp_last_in_step,
   input  logic                                   rsp_finished,
   output int                                     fail_count,
   output int                                     pending_spans,
   output int                                     span_count,
   output int                                     empty_count,
   output int                                     finished_count
);

   localparam int SB = mcsg_pkg::SPAN_BITS;
   localparam int CB = mcsg_pkg::COLOR_BITS;
   localparam int IB = mcsg_pkg::IN_BITS;

   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic signed [SB-1:0] row;
      logic [CB-1:0]        color;
      logic                 span_valid;
      logic                 last_in_step;
      logic                 finished;
   } span_rec_type;

   span_rec_type expected_spans[$];

   logic          walk_busy;
   logic          walk_mode;
   logic [CB-1:0] walk_color;
   int            center_col;
   int            center_row;
   int            walk_radius;
   int            walk_x;
   int            walk_y;
   int            error_term;
   int            x_step;
   int            y_step;

   function automatic span_rec_type make_span(int left, int right, int row);
      span_rec_type s;
      s.left         = left[SB-1:0];
      s.right        = right[SB-1:0];
      s.row          = row[SB-1:0];
      s.color        = walk_color;
      s.span_valid   = 1'b1;
      s.last_in_step = 1'b0;
      s.finished     = 1'b0;
      return s;
   endfunction

   task automatic advance_walk();
      if (walk_mode == mcsg_pkg::MODE_OUTLINE) begin
         if (error_term <= 0) begin
            walk_y     += 1;
            error_term += y_step;
            y_step     += 2;
         end
         if (error_term > 0) begin
            walk_x     -= 1;
            x_step     += 2;
            error_term += x_step - 2 * walk_radius;
         end
      end else begin
         walk_y     += 1;
         error_term += y_step;
         y_step     += 2;
         if (2 * error_term + x_step > 0) begin
            walk_x     -= 1;
            error_term += x_step;
            x_step     += 2;
         end
      end
   endtask

   task automatic predict_transaction(input logic kind, input logic [IB-1:0] in_cx,
                                      input logic [IB-1:0] in_cy,
                                      input logic [IB-1:0] in_radius, input logic in_fill,
                                      input logic [CB-1:0] in_color);
      span_rec_type batch[8];
      int           n;
      int           cx;
      int           cy;
      int           x;
      int           y;
      n = 0;
      if (kind == mcsg_pkg::ACTION_START) begin
         center_col  = int'(in_cx);
         center_row  = int'(in_cy);
         walk_radius = int'(in_radius);
         walk_mode   = in_fill;
         walk_color  = in_color;
         walk_y      = 0;
         if (walk_mode == mcsg_pkg::MODE_OUTLINE) begin
            walk_x     = walk_radius - 1;
            x_step     = 1;
            y_step     = 1;
            error_term = 1 - 2 * walk_radius;
         end else begin
            walk_x     = walk_radius;
            x_step     = 1 - 2 * walk_radius;
            y_step     = 0;
            error_term = 0;
         end
         walk_busy = 1'b1;
      end else if (!walk_busy || walk_x < walk_y) begin
         walk_busy = 1'b0;
         batch[0] = '0;
         batch[0].last_in_step = 1'b1;
         batch[0].finished     = 1'b1;
         n = 1;
      end else begin
         cx = center_col;
         cy = center_row;
         x  = walk_x;
         y  = walk_y;
         if (walk_mode == mcsg_pkg::MODE_OUTLINE) begin
            batch[0] = make_span(cx + x, cx + x, cy + y);
            batch[1] = make_span(cx + y, cx + y, cy + x);
            batch[2] = make_span(cx - y, cx - y, cy + x);
            batch[3] = make_span(cx - x, cx - x, cy + y);
            batch[4] = make_span(cx - x, cx - x, cy - y);
            batch[5] = make_span(cx - y, cx - y, cy - x);
            batch[6] = make_span(cx + y, cx + y, cy - x);
            batch[7] = make_span(cx + x, cx + x, cy - y);
            n = 8;
         end else begin
            batch[0] = make_span(cx - x, cx + x, cy + y);
            batch[1] = make_span(cx - x, cx + x, cy - y);
            batch[2] = make_span(cx - y, cx + y, cy + x);
            batch[3] = make_span(cx - y, cx + y, cy - x);
            n = 4;
         end
         advance_walk();
         batch[n-1].last_in_step = 1'b1;
         if (walk_x < walk_y) begin
            walk_busy = 1'b0;
            batch[n-1].finished = 1'b1;
         end
      end
      for (int i = 0; i < n; i++) expected_spans.push_back(batch[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      span_rec_type want;
      if (reset) begin
         expected_spans.delete();
         walk_busy      = 1'b0;
         walk_mode      = mcsg_pkg::MODE_OUTLINE;
         walk_color     = '0;
         center_col     = 0;
         center_row     = 0;
         walk_radius    = 0;
         walk_x         = 0;
         walk_y         = 0;
         error_term     = 0;
         x_step         = 0;
         y_step         = 0;
         fail_count     = 0;
         span_count     = 0;
         empty_count    = 0;
         finished_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               $display("%0t: unexpected span transaction, expected none, actual row %0d",
                        $time, rsp_span_row);
               fail_count++;
            end else begin
               want = expected_spans.pop_front();
               check_field("span_left", int'(want.left), int'(rsp_span_left));
               check_field("span_right", int'(want.right), int'(rsp_span_right));
               check_field("span_row", int'(want.row), int'(rsp_span_row));
               check_field("span_color", int'(want.color), int'(rsp_span_color));
               check_field("span_valid", int'(want.span_valid), int'(rsp_span_valid));
               check_field("last_in_step", int'(want.last_in_step),
                           int'(rsp_last_in_step));
               check_field("finished", int'(want.finished), int'(rsp_finished));
               if (want.span_valid) span_count++;
               else empty_count++;
               if (want.finished && want.span_valid) finished_count++;
            end
         end
         if (req_valid && req_ready)
            predict_transaction(req_action, req_center_x, req_center_y, req_radius,
                                req_fill_mode, req_color);
      end
      pending_spans = expected_spans.size();
   end

endmodule

@@ dv/testbench.sv @@
// Top of the circle span generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int IN_W         = mcsg_pkg::IN_BITS;
   localparam int COLOR_W      = mcsg_pkg::COLOR_BITS;
   localparam int SPAN_W       = mcsg_pkg::SPAN_BITS;
   localparam int RANDOM_ITEMS = 195;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 150000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_action;
   logic [IN_W-1:0]          req_center_x;
   logic [IN_W-1:0]          req_center_y;
   logic [IN_W-1:0]          req_radius;
   logic                     req_fill_mode;
   logic [COLOR_W-1:0]       req_color;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [SPAN_W-1:0] rsp_span_left;
   logic signed [SPAN_W-1:0] rsp_span_right;
   logic signed [SPAN_W-1:0] rsp_span_row;
   logic [COLOR_W-1:0]       rsp_span_color;
   logic                     rsp_span_valid;
   logic                     rsp_last_in_step;
   logic                     rsp_finished;

   int fail_count;
   int pending_spans;
   int span_count;
   int empty_count;
   int finished_count;

   int items_sent;
   int starts_sent;
   int directed_items;
   int burst_left;
   int cycle_count;
   int seg_left;
   int seg_mode;
   int pick;
   int steps;
   bit long_hold_request;
   bit long_hold_done;
   logic [IN_W-1:0] rand_radius;

   midpoint_circle_span_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .req_fill_mode    (req_fill_mode),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_span_left    (rsp_span_left),
      .rsp_span_right   (rsp_span_right),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_color   (rsp_span_color),
      .rsp_span_valid   (rsp_span_valid),
      .rsp_last_in_step (rsp_last_in_step),
      .rsp_finished     (rsp_finished)
   );

   circle_span_monitor span_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .req_fill_mode    (req_fill_mode),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_span_left    (rsp_span_left),
      .rsp_span_right   (rsp_span_right),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_color   (rsp_span_color),
      .rsp_span_valid   (rsp_span_valid),
      .rsp_last_in_step (rsp_last_in_step),
      .rsp_finished     (rsp_finished),
      .fail_count       (fail_count),
      .pending_spans    (pending_spans),
      .span_count       (span_count),
      .empty_count      (empty_count),
      .finished_count   (finished_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d spans still expected", cycle_count,
                  pending_spans);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_transaction(input logic kind, input logic [IN_W-1:0] cx,
                                   input logic [IN_W-1:0] cy,
                                   input logic [IN_W-1:0] radius, input logic fill,
                                   input logic [COLOR_W-1:0] color);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_action    <= kind;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_radius    <= radius;
      req_fill_mode <= fill;
      req_color     <= color;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == mcsg_pkg::ACTION_START) starts_sent++;
   endtask

   task automatic start_circle(input logic [IN_W-1:0] cx, input logic [IN_W-1:0] cy,
                               input logic [IN_W-1:0] radius, input logic fill,
                               input logic [COLOR_W-1:0] color);
      send_transaction(mcsg_pkg::ACTION_START, cx, cy, radius, fill, color);
   endtask

   // step fields are ignored by the block; randomize them anyway
   task automatic step_circle();
      send_transaction(mcsg_pkg::ACTION_STEP, IN_W'($urandom_range(0, 1023)),
                       IN_W'($urandom_range(0, 1023)), IN_W'($urandom_range(0, 1023)),
                       1'($urandom_range(0, 1)), COLOR_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      rsp_ready = 1'b0;
      seg_left  = 0;
      seg_mode  = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request && !long_hold_done) begin
            rsp_ready <= 1'b0;
            long_hold_done = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (seg_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = mcsg_pkg::ACTION_START;
      req_center_x  = '0;
      req_center_y  = '0;
      req_radius    = '0;
      req_fill_mode = mcsg_pkg::MODE_OUTLINE;
      req_color     = '0;
      items_sent    = 0;
      starts_sent   = 0;
      burst_left    = 0;
      cycle_count   = 0;
      long_hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_transaction(mcsg_pkg::ACTION_STEP, '0, '0, '0, mcsg_pkg::MODE_OUTLINE, '0);
      start_circle(10'd0, 10'd0, 10'd0, mcsg_pkg::MODE_OUTLINE, 16'h0000);
      repeat (2) step_circle();
      start_circle(10'd1023, 10'd1023, 10'd1, mcsg_pkg::MODE_OUTLINE, 16'hFFFF);
      repeat (2) step_circle();
      start_circle(10'd512, 10'd0, 10'd0, mcsg_pkg::MODE_FILLED, 16'hA5A5);
      step_circle();
      start_circle(10'd0, 10'd1023, 10'd1023, mcsg_pkg::MODE_FILLED, 16'h5A5A);
      repeat (2) step_circle();
      start_circle(10'd1023, 10'd0, 10'd1023, mcsg_pkg::MODE_OUTLINE, 16'hFFFF);
      repeat (2) step_circle();
      start_circle(10'd1023, 10'd1023, 10'd3, mcsg_pkg::MODE_FILLED, 16'hFFFF);
      repeat (4) step_circle();
      start_circle(10'd0, 10'd0, 10'd5, mcsg_pkg::MODE_OUTLINE, 16'h0001);
      repeat (4) step_circle();
      directed_items = items_sent;

      long_hold_request = 1'b1;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) rand_radius = IN_W'($urandom_range(0, 24));
            else if (pick < 9) rand_radius = IN_W'($urandom_range(25, 40));
            else rand_radius = IN_W'($urandom_range(0, 1023));
            steps = (rand_radius <= 40) ? $urandom_range(1, rand_radius + 3)
                                        : $urandom_range(1, 10);
            start_circle(IN_W'($urandom_range(0, 1023)), IN_W'($urandom_range(0, 1023)),
                         rand_radius, 1'($urandom_range(0, 1)),
                         COLOR_W'($urandom_range(0, 65535)));
            repeat (steps) step_circle();
         end else begin
            send_transaction(1'($urandom_range(0, 1)), IN_W'($urandom_range(0, 1023)),
                             IN_W'($urandom_range(0, 1023)), IN_W'($urandom_range(0, 1023)),
                             1'($urandom_range(0, 1)), COLOR_W'($urandom_range(0, 65535)));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_spans != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (%0d starts, outline and filled, with stalls).",
               items_sent, starts_sent);
      $display("Checked %0d spans and %0d empty results; %0d circles ran to completion.",
               span_count, empty_count, finished_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mcsg_pkg.sv
hdl/mcsg_front.sv
hdl/mcsg_queue.sv
hdl/mcsg_back.sv
hdl/midpoint_circle_span_generator.sv
dv/circle_span_monitor.sv
dv/testbench.sv
